// ===== hw/rtl/vpts_pkg.sv =====
`timescale 1ns / 1ps
package vpts_pkg;

  localparam int CoordW   = 32;
  localparam int CoefW    = 16;
  localparam int ProdW    = CoordW + CoefW;
  localparam int ClipW    = ProdW + 4;
  localparam int QFrac    = 16;
  localparam int QW       = CoordW + 1;
  localparam int DivSteps = CoordW;
  localparam int DivLat   = DivSteps + 1;
  localparam int PipeLat  = DivLat + 7;
  localparam int SizeW    = 13;
  localparam int AddrW    = 6;
  localparam int DataW    = 64;

  localparam logic [1:0] STATUS_VISIBLE  = 2'd0;
  localparam logic [1:0] STATUS_CULLED   = 2'd1;
  localparam logic [1:0] STATUS_ZERO_DIV = 2'd2;

  typedef enum logic [2:0] {
    REG_ROW_X,
    REG_ROW_Y,
    REG_ROW_Z,
    REG_ROW_W,
    REG_WIDTH,
    REG_HEIGHT
  } reg_idx_e;

  typedef struct packed {
    logic signed [CoordW-1:0] vertex_x;
    logic signed [CoordW-1:0] vertex_y;
    logic signed [CoordW-1:0] vertex_z;
  } vertex_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [CoordW-1:0] screen_x;
    logic signed [CoordW-1:0] screen_y;
    logic signed [CoordW-1:0] depth;
  } result_t;

  typedef struct packed {
    logic [1:0] status;
    logic       neg_x;
    logic       neg_y;
    logic       neg_z;
  } side_t;

  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [ProdW-1:0] v);
    logic signed [ProdW-1:0] hi;
    logic signed [ProdW-1:0] lo;
    hi = ProdW'({1'b0, {(CoordW-1){1'b1}}});
    lo = -hi - ProdW'(1);
    if (v > hi) return hi[CoordW-1:0];
    if (v < lo) return lo[CoordW-1:0];
    return v[CoordW-1:0];
  endfunction

endpackage

// ===== hw/rtl/vpts_div.sv =====
`timescale 1ns / 1ps
module vpts_div import vpts_pkg::*; (
  input  logic            clk_i,
  input  logic [ClipW-1:0] num_i,
  input  logic [ClipW-1:0] den_i,
  output logic [QW-1:0]    quo_o
);

  localparam int RemW = ClipW + 1;

  logic [RemW-1:0]     rem_q [DivSteps+1];
  logic [DivSteps-1:0] lo_q  [DivSteps+1];
  logic [ClipW-1:0]    den_q [DivSteps+1];
  logic                ovf_q [DivSteps+1];
  logic [RemW-1:0]     rem_d [DivSteps];
  logic [DivSteps-1:0] lo_d  [DivSteps];

  always_comb begin
    for (int k = 0; k < DivSteps; k++) begin
      logic [RemW-1:0] trial;
      logic            ge;
      trial    = {rem_q[k][RemW-2:0], lo_q[k][DivSteps-1]};
      ge       = trial >= {1'b0, den_q[k]};
      rem_d[k] = ge ? trial - {1'b0, den_q[k]} : trial;
      lo_d[k]  = {lo_q[k][DivSteps-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    ovf_q[0] <= (num_i >> QFrac) >= den_i;
    rem_q[0] <= RemW'(num_i >> QFrac);
    lo_q[0]  <= {num_i[QFrac-1:0], {(DivSteps-QFrac){1'b0}}};
    den_q[0] <= den_i;
    for (int k = 0; k < DivSteps; k++) begin
      ovf_q[k+1] <= ovf_q[k];
      rem_q[k+1] <= rem_d[k];
      lo_q[k+1]  <= lo_d[k];
      den_q[k+1] <= den_q[k];
    end
  end

  assign quo_o = ovf_q[DivSteps] ? {1'b1, {DivSteps{1'b0}}} : {1'b0, lo_q[DivSteps]};

endmodule

// ===== hw/rtl/vertex_project_to_screen_unit.sv =====
`timescale 1ns / 1ps
// Vertex projection unit. A vertex request is taken in every cycle (busy
// stays low). Its result shows on result_o, with done_o high for one cycle.
// Results come in request order. The pipeline is four transform stages, a
// 33-stage quotient pipeline (an input stage, then one quotient bit per
// stage), and three sign, viewport and output stages. The receiver cannot
// stall the unit. Write the matrix and screen size registers only while no
// request is in flight.
module vertex_project_to_screen_unit import vpts_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  vertex_t          vertex_i,
  output logic             done_o,
  output result_t          result_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  logic [DataW-1:0] row_q [4];
  logic [SizeW-1:0] width_q, height_q;
  reg_idx_e         ridx;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign ridx   = reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 4; r++) row_q[r] <= '0;
      width_q  <= SizeW'(640);
      height_q <= SizeW'(480);
    end else if (psel && penable && pwrite) begin
      case (ridx)
        REG_ROW_X:  row_q[0] <= pwdata;
        REG_ROW_Y:  row_q[1] <= pwdata;
        REG_ROW_Z:  row_q[2] <= pwdata;
        REG_ROW_W:  row_q[3] <= pwdata;
        REG_WIDTH:  width_q  <= pwdata[SizeW-1:0];
        REG_HEIGHT: height_q <= pwdata[SizeW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_ROW_X:  prdata = row_q[0];
      REG_ROW_Y:  prdata = row_q[1];
      REG_ROW_Z:  prdata = row_q[2];
      REG_ROW_W:  prdata = row_q[3];
      REG_WIDTH:  prdata = DataW'(width_q);
      REG_HEIGHT: prdata = DataW'(height_q);
      default:    prdata = '0;
    endcase
  end

  // valid line over the whole pipe
  logic [PipeLat-2:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= {vld_q[PipeLat-3:0], start && !busy};
  end

  // s1: capture
  logic signed [CoordW-1:0] v_q [3];
  always_ff @(posedge clk_i) begin
    v_q[0] <= vertex_i.vertex_x;
    v_q[1] <= vertex_i.vertex_y;
    v_q[2] <= vertex_i.vertex_z;
  end

  // s2: products
  logic signed [ProdW-1:0] prod_q [4][3];
  logic signed [ClipW-1:0] cst_q  [4];
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 4; r++) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [CoefW-1:0] c;
        c = $signed(row_q[r][CoefW*i +: CoefW]);
        prod_q[r][i] <= c * v_q[i];
      end
      cst_q[r] <= {{(ClipW-CoefW-QFrac){row_q[r][DataW-1]}},
                   row_q[r][DataW-1 -: CoefW], {QFrac{1'b0}}};
    end
  end

  // s3: clip coordinates
  logic signed [ClipW-1:0] clip_q [4];
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 4; r++) begin
      clip_q[r] <= ClipW'(prod_q[r][0]) + ClipW'(prod_q[r][1]) + ClipW'(prod_q[r][2])
                 + cst_q[r];
    end
  end

  // s4: clip test, magnitudes
  logic [ClipW-1:0] mag_q [4];
  side_t            side_q;
  always_ff @(posedge clk_i) begin
    logic signed [ClipW-1:0] zc, wc;
    zc = clip_q[2];
    wc = clip_q[3];
    for (int r = 0; r < 4; r++) mag_q[r] <= clip_q[r][ClipW-1] ? -clip_q[r] : clip_q[r];
    if (wc[ClipW-1] || zc < -wc || zc > wc) side_q.status <= STATUS_CULLED;
    else if (wc == '0 || zc == '0)         side_q.status <= STATUS_ZERO_DIV;
    else                                   side_q.status <= STATUS_VISIBLE;
    side_q.neg_x <= clip_q[0][ClipW-1] ^ zc[ClipW-1];
    side_q.neg_y <= clip_q[1][ClipW-1] ^ zc[ClipW-1];
    side_q.neg_z <= zc[ClipW-1] ^ wc[ClipW-1];
  end

  logic [QW-1:0] qx, qy, qz;
  vpts_div u_div_x (.clk_i, .num_i(mag_q[0]), .den_i(mag_q[2]), .quo_o(qx));
  vpts_div u_div_y (.clk_i, .num_i(mag_q[1]), .den_i(mag_q[2]), .quo_o(qy));
  vpts_div u_div_z (.clk_i, .num_i(mag_q[2]), .den_i(mag_q[3]), .quo_o(qz));

  side_t side_dl_q [DivLat];
  always_ff @(posedge clk_i) begin
    side_dl_q[0] <= side_q;
    for (int k = 1; k < DivLat; k++) side_dl_q[k] <= side_dl_q[k-1];
  end

  // p1: sign and saturate
  side_t                    p1_side_q;
  logic signed [CoordW-1:0] ndc_x_q, ndc_y_q, dep_q;
  always_ff @(posedge clk_i) begin
    side_t sd;
    sd = side_dl_q[DivLat-1];
    p1_side_q <= sd;
    ndc_x_q <= sat_coord(sd.neg_x ? -ProdW'(qx) : ProdW'(qx));
    ndc_y_q <= sat_coord(sd.neg_y ? -ProdW'(qy) : ProdW'(qy));
    dep_q   <= sat_coord(sd.neg_z ? -ProdW'(qz) : ProdW'(qz));
  end

  // p2: viewport scale
  localparam int PW = CoordW + SizeW + 2;
  logic [1:0]               p2_status_q;
  logic signed [PW-1:0]     px_q, py_q;
  logic signed [CoordW-1:0] p2_dep_q;
  always_ff @(posedge clk_i) begin
    logic signed [CoordW:0] ox, oy;
    ox = CoordW'(1) + {ndc_x_q[CoordW-1], ndc_x_q} + (CoordW+1)'(65535);
    oy = CoordW'(1) + {ndc_y_q[CoordW-1], ndc_y_q} + (CoordW+1)'(65535);
    p2_status_q <= p1_side_q.status;
    p2_dep_q    <= dep_q;
    px_q <= PW'(ox) * PW'($signed({1'b0, width_q}));
    py_q <= PW'(oy) * PW'($signed({1'b0, height_q}));
  end

  // p3: halve, saturate, output
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= vld_q[PipeLat-2];
  end

  always_ff @(posedge clk_i) begin
    result_o.status <= p2_status_q;
    if (p2_status_q == STATUS_VISIBLE) begin
      result_o.screen_x <= sat_coord(ProdW'(px_q >>> 1));
      result_o.screen_y <= sat_coord(ProdW'(py_q >>> 1));
      result_o.depth    <= p2_dep_q;
    end else begin
      result_o.screen_x <= '0;
      result_o.screen_y <= '0;
      result_o.depth    <= '0;
    end
  end

endmodule

// ===== hw/rtl/vpts_checker.sv =====
`timescale 1ns / 1ps
module vpts_checker import vpts_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input logic    done_o,
  input result_t result_o
);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##PipeLat done_o)
    else $error("request without result");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, PipeLat))
    else $error("result without request");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> result_o.status == STATUS_VISIBLE || result_o.status == STATUS_CULLED
               || result_o.status == STATUS_ZERO_DIV)
    else $error("bad status");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.status != STATUS_VISIBLE |->
      result_o.screen_x == '0 && result_o.screen_y == '0 && result_o.depth == '0)
    else $error("nonzero fields on rejected vertex");

endmodule

bind vertex_project_to_screen_unit vpts_checker u_vpts_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import vpts_pkg::*;

  localparam int IdleLimit = 2000;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  vertex_t          vertex_i;
  logic             done_o;
  result_t          result_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  vertex_project_to_screen_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .vertex_i (vertex_i),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // shadow copy of the unit's registers
  logic [63:0] mat_row [4];
  logic [63:0] scr_w;
  logic [63:0] scr_h;

  result_t     pending_q[$];
  bit          failed;
  bit          no_gaps;
  int          idle_cycles;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clip_sum(logic [63:0] row, vertex_t vtx);
    longint acc;
    acc = longint'($signed(row[15:0])) * longint'(vtx.vertex_x)
        + longint'($signed(row[31:16])) * longint'(vtx.vertex_y)
        + longint'($signed(row[47:32])) * longint'(vtx.vertex_z)
        + longint'($signed(row[63:48])) * 64'sd65536;
    return acc;
  endfunction

  // signed n/d to Q16.16, magnitude truncated, capped at 2^32
  function automatic longint quot_q16(longint n, longint d);
    logic [63:0] un, ud, q, r, res;
    un = (n < 0) ? 64'(-n) : 64'(n);
    ud = (d < 0) ? 64'(-d) : 64'(d);
    q  = un / ud;
    r  = un % ud;
    if (q >= 64'd65536) begin
      res = 64'd1 << 32;
    end else begin
      res = q;
      for (int i = 0; i < 16; i++) begin
        res = res << 1;
        if (r >= ud - r) begin
          r   = r - (ud - r);
          res = res | 64'd1;
        end else begin
          r = r + r;
        end
      end
    end
    return ((n < 0) != (d < 0)) ? -longint'(res) : longint'(res);
  endfunction

  function automatic longint viewport(longint ndc, logic [63:0] size);
    logic [63:0] p;
    p = (64'(sat32(ndc)) + 64'd65536) * size;
    return sat32($signed(p) >>> 1);
  endfunction

  function automatic result_t project(vertex_t vtx);
    result_t res;
    longint  xc, yc, zc, wc;
    xc = clip_sum(mat_row[0], vtx);
    yc = clip_sum(mat_row[1], vtx);
    zc = clip_sum(mat_row[2], vtx);
    wc = clip_sum(mat_row[3], vtx);
    res = '0;
    if (wc < 0 || zc < -wc || zc > wc) begin
      res.status = STATUS_CULLED;
    end else if (wc == 0 || zc == 0) begin
      res.status = STATUS_ZERO_DIV;
    end else begin
      res.status   = STATUS_VISIBLE;
      res.screen_x = 32'(viewport(quot_q16(xc, zc), scr_w));
      res.screen_y = 32'(viewport(quot_q16(yc, zc), scr_h));
      res.depth    = 32'(sat32(quot_q16(zc, wc)));
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic reg_write(reg_idx_e idx, logic [63:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = AddrW'(idx) << 3;
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_WIDTH:  scr_w = val & 64'h1fff;
      REG_HEIGHT: scr_h = val & 64'h1fff;
      default:    mat_row[int'(idx)] = val;
    endcase
  endtask

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    start             = 1'b1;
    vertex_i.vertex_x = x;
    vertex_i.vertex_y = y;
    vertex_i.vertex_z = z;
    do @(posedge clk_i); while (busy);
    pending_q.push_back(project(vertex_i));
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    start = 1'b0;
    wait (pending_q.size() == 0);
    repeat (PipeLat + 5) @(negedge clk_i);
  endtask

  task automatic set_matrix(logic [63:0] rx, logic [63:0] ry, logic [63:0] rz,
                            logic [63:0] rw, logic [63:0] w, logic [63:0] h);
    reg_write(REG_ROW_X, rx);
    reg_write(REG_ROW_Y, ry);
    reg_write(REG_ROW_Z, rz);
    reg_write(REG_ROW_W, rw);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 262144)) - 131072);
      2: return 32'($signed($urandom_range(0, 33554432)) - 16777216);
      3: begin
        case ($urandom_range(0, 5))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 32'h0;
          3: return 32'hffffffff;
          4: return 32'h00010000;
          default: return 32'hffff0000;
        endcase
      end
      default: return 32'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic logic [15:0] rand_coef(bit wild);
    if (wild) begin
      case ($urandom_range(0, 3))
        0: return 16'h7fff;
        1: return 16'h8000;
        default: return 16'($urandom);
      endcase
    end
    return 16'($signed($urandom_range(0, 16384)) - 8192);
  endfunction

  function automatic logic [63:0] pick_size();
    case ($urandom_range(0, 6))
      0: return 64'd1;
      1: return 64'd4096;
      2: return 64'd0;
      3: return 64'd8191;
      4: return 64'd640;
      default: return 64'($urandom_range(1, 4096));
    endcase
  endfunction

  task automatic test_reset_values();
    send_vertex(32'h00010000, 32'h00020000, 32'h00008000);
    send_vertex(32'h7fffffff, 32'h80000000, 32'h0);
    drain();
  endtask

  task automatic test_directed();
    set_matrix(64'h1000, 64'h1000_0000, 64'h1000_0000_0000, 64'h1000_0000_0000_0000,
               64'd640, 64'd480);
    send_vertex(32'h0, 32'h0, 32'h00008000);
    send_vertex(32'h00004000, 32'hffffc000, 32'hffff8000);
    send_vertex(32'h0, 32'h0, 32'h0);
    send_vertex(32'h0, 32'h0, 32'h00020000);
    send_vertex(32'h0, 32'h0, 32'hfffe0000);
    send_vertex(32'h0, 32'h0, 32'h00010000);
    send_vertex(32'h7fffffff, 32'h80000000, 32'h00000001);
    send_vertex(32'h80000000, 32'h7fffffff, 32'hffffffff);
    send_vertex(32'h00010000, 32'hffff0000, 32'h00010000);
    send_vertex(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_vertex(32'h80000000, 32'h80000000, 32'h80000000);
    drain();
    set_matrix(64'h1000, 64'h1000_0000, 64'h1000_0000_0000, 64'hf000_0000_0000_0000,
               64'd4096, 64'd1);
    send_vertex(32'h0, 32'h0, 32'h0);
    send_vertex(32'h00001000, 32'h00002000, 32'hffff8000);
    drain();
    set_matrix(64'h8000_7fff_8000_7fff, 64'h7fff_8000_7fff_8000,
               64'h0000_0000_0100_0000, 64'h7fff_0000_0000_0000, 64'd8191, 64'd0);
    send_vertex(32'h00010000, 32'h00010000, 32'h00010000);
    send_vertex(32'h7fffffff, 32'h80000000, 32'h00400000);
    send_vertex(32'h80000000, 32'h7fffffff, 32'hffc00000);
    send_vertex(32'h0, 32'h0, 32'h00000001);
    send_vertex(32'h12345678, 32'hedcba987, 32'h00000000);
    drain();
  endtask

  task automatic test_random_phase(int count, bit wild);
    logic [63:0] rows [4];
    for (int r = 0; r < 4; r++)
      rows[r] = {rand_coef(wild), rand_coef(wild), rand_coef(wild), rand_coef(wild)};
    if (!wild) begin
      // keep w dominated by a large constant so most vertices survive the clip test
      rows[3][63:48] = 16'($urandom_range(2048, 32767));
      rows[2][47:32] = 16'($signed($urandom_range(0, 8192)) - 4096);
      rows[2][63:48] = 16'($signed($urandom_range(0, 4096)) - 2048);
    end
    set_matrix(rows[0], rows[1], rows[2], rows[3], pick_size(), pick_size());
    no_gaps = ($urandom_range(0, 3) == 0);
    repeat (count) send_vertex(rand_coord(), rand_coord(), rand_coord());
    no_gaps = 1'b0;
    drain();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_q.size() == 0) begin
        $error("result with no request outstanding");
        failed = 1'b1;
      end else begin
        result_t exp_res;
        exp_res = pending_q.pop_front();
        if (result_o.status !== exp_res.status) begin
          $error("status expected %0d got %0d", exp_res.status, result_o.status);
          failed = 1'b1;
        end
        if (result_o.screen_x !== exp_res.screen_x) begin
          $error("screen_x expected %0d got %0d", exp_res.screen_x, result_o.screen_x);
          failed = 1'b1;
        end
        if (result_o.screen_y !== exp_res.screen_y) begin
          $error("screen_y expected %0d got %0d", exp_res.screen_y, result_o.screen_y);
          failed = 1'b1;
        end
        if (result_o.depth !== exp_res.depth) begin
          $error("depth expected %0d got %0d", exp_res.depth, result_o.depth);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("vertex_project_to_screen_unit: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    vertex_i   = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    failed     = 1'b0;
    no_gaps    = 1'b0;
    mat_row[0] = '0;
    mat_row[1] = '0;
    mat_row[2] = '0;
    mat_row[3] = '0;
    scr_w      = 64'd640;
    scr_h      = 64'd480;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_values();
    test_directed();
    for (int p = 0; p < 10; p++) test_random_phase(110, 1'b0);
    for (int p = 0; p < 3; p++) test_random_phase(100, 1'b1);

    if (!failed) begin
      $display("vertex_project_to_screen_unit: match");
    end else begin
      $display("vertex_project_to_screen_unit: mismatch");
    end
    $finish;
  end

endmodule
